FILE: hdl/histogram_mode_finder_core_defines.svh
// Assertion macros shared by the histogram mode finder RTL.
// Depends on clk and arst_n being visible in the module that uses them.
`ifndef HISTOGRAM_MODE_FINDER_CORE_DEFINES_SVH
`define HISTOGRAM_MODE_FINDER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define HMF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define HMF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/hmf_pkg.sv
// Package for the histogram mode finder: field widths and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package hmf_pkg;

	localparam int COV_W        = 12;
	localparam int PEAK_VALUE_W = 12;
	localparam int PEAK_COUNT_W = 16;

	// Controller -> datapath
	typedef struct packed {
		logic capture;   // input transfer: latch bin/last, read bin count
		logic upd;       // write bumped count, update running best
		logic emit;      // load result register, clear running best
		logic clr_step;  // write zero at clear pointer, advance
	} hmf_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic last_item; // item being updated ends the run
		logic out_free;  // result register can take a new result
		logic clr_last;  // clear pointer at top bin
	} hmf_stat_t;

endpackage

FILE: hdl/hmf_datapath.sv
// Datapath of the histogram mode finder: histogram memory, running best,
// clear pointer and result register. Depends on hmf_pkg.
`timescale 1ns / 1ps

module hmf_datapath
	import hmf_pkg::*;
#(
	parameter int BINS        = 4096,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [COV_W-1:0]        coverage,
	input  logic                    last,
	input  hmf_cmd_t                cmd,
	output hmf_stat_t               stat,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [PEAK_VALUE_W-1:0] peak_value,
	output logic [PEAK_COUNT_W-1:0] peak_count
);

	localparam int BIN_W = (BINS > 1) ? $clog2(BINS) : 1;
	localparam int CMP_W = (BIN_W > COV_W) ? BIN_W : COV_W;
	localparam logic [CMP_W-1:0]       TOP_BIN = CMP_W'(BINS - 1);
	localparam logic [BIN_W-1:0]       LAST_ADDR = BIN_W'(BINS - 1);
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	logic [COUNT_WIDTH-1:0] hist_mem [BINS];

	logic [CMP_W-1:0]       cov_ext;
	logic [BIN_W-1:0]       bin_in;
	logic [BIN_W-1:0]       bin_q;
	logic                   last_q;
	logic [COUNT_WIDTH-1:0] rd_data_q;
	logic [BIN_W-1:0]       clr_cnt_q;
	logic [BIN_W-1:0]       best_val_q;
	logic [COUNT_WIDTH-1:0] best_cnt_q;
	logic [COUNT_WIDTH-1:0] cnt_new;
	logic                   better;
	logic [BIN_W-1:0]       nb_val;
	logic [COUNT_WIDTH-1:0] nb_cnt;
	logic                   wr_en;
	logic [BIN_W-1:0]       wr_addr;
	logic [COUNT_WIDTH-1:0] wr_data;
	logic                   out_valid_q;
	logic [PEAK_VALUE_W-1:0] peak_value_q;
	logic [PEAK_COUNT_W-1:0] peak_count_q;

	// Clamp into the top bin
	assign cov_ext = CMP_W'(coverage);
	assign bin_in  = (cov_ext > TOP_BIN) ? BIN_W'(TOP_BIN) : BIN_W'(cov_ext);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			bin_q     <= bin_in;
			rd_data_q <= hist_mem[bin_in];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b0;
		end else if (cmd.capture) begin
			last_q <= last;
		end
	end

	// Saturating bump and running-best compare (ties go to the smaller bin)
	assign cnt_new = (rd_data_q == CNT_MAX) ? rd_data_q : rd_data_q + 1'b1;
	assign better  = (cnt_new > best_cnt_q) ||
	                 ((cnt_new == best_cnt_q) && (bin_q < best_val_q));
	assign nb_val  = better ? bin_q : best_val_q;
	assign nb_cnt  = better ? cnt_new : best_cnt_q;

	// Single write port shared by update and clear sweep
	assign wr_en   = cmd.upd || cmd.clr_step;
	assign wr_addr = cmd.clr_step ? clr_cnt_q : bin_q;
	assign wr_data = cmd.clr_step ? '0 : cnt_new;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			hist_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_step) begin
			clr_cnt_q <= (clr_cnt_q == LAST_ADDR) ? '0 : clr_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_val_q <= '0;
			best_cnt_q <= '0;
		end else if (cmd.upd) begin
			if (cmd.emit) begin
				best_val_q <= '0;
				best_cnt_q <= '0;
			end else begin
				best_val_q <= nb_val;
				best_cnt_q <= nb_cnt;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			peak_value_q <= PEAK_VALUE_W'(nb_val);
			peak_count_q <= PEAK_COUNT_W'(nb_cnt);
		end
	end

	assign out_valid  = out_valid_q;
	assign peak_value = peak_value_q;
	assign peak_count = peak_count_q;

	assign stat.last_item = last_q;
	assign stat.out_free  = !out_valid_q || out_ready;
	assign stat.clr_last  = (clr_cnt_q == LAST_ADDR);

endmodule

FILE: hdl/hmf_ctrl.sv
// Controller of the histogram mode finder: clear sweep, accept and update
// sequencing. Depends on hmf_pkg and histogram_mode_finder_core_defines.svh.
`timescale 1ns / 1ps
`include "histogram_mode_finder_core_defines.svh"

module hmf_ctrl
	import hmf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  hmf_stat_t stat,
	output hmf_cmd_t  cmd
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_UPD   = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_UPD;
				end
			end
			ST_UPD: begin
				// a final item waits here until the result register frees up
				if (!stat.last_item || stat.out_free) begin
					cmd.upd = 1'b1;
					if (stat.last_item) begin
						cmd.emit = 1'b1;
						state_d  = ST_CLEAR;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	`HMF_ASSERT_NEXT(a_accept_to_upd, in_valid && in_ready, state_q == ST_UPD, "transfer not followed by update")
	`HMF_ASSERT_NEXT(a_final_clears, (state_q == ST_UPD) && stat.last_item && stat.out_free, state_q == ST_CLEAR, "run end did not start clear")
	`HMF_ASSERT_NOW(a_emit_free, cmd.emit, stat.out_free, "result loaded while register busy")
	`HMF_ASSERT_NEXT(a_clear_done, (state_q == ST_CLEAR) && stat.clr_last, state_q == ST_IDLE, "clear sweep overran")

endmodule

FILE: hdl/histogram_mode_finder_core.sv
// Top level of the histogram mode finder: controller plus datapath.
// Depends on hmf_pkg, hmf_ctrl and hmf_datapath.
//
//  channel | signals                       | direction
//  --------+-------------------------------+-----------
//  in      | in_valid/in_ready, coverage,  | into block
//          | last                          |
//  out     | out_valid/out_ready,          | out of block
//          | peak_value, peak_count        |
//
// Each item is first read from its bin in the histogram memory (registered
// read port), then its bumped count is written back and the running best
// updated. The next item is not read until that write has landed.
// After reset, and after every item marked last, a clear sweep writes zero to
// all BINS bins, one per cycle; no item is accepted during the sweep.
// A final item holds in its update cycle while the result register is still
// full; items that are not final never wait on out_ready.
`timescale 1ns / 1ps

module histogram_mode_finder_core
	import hmf_pkg::*;
#(
	parameter int BINS        = 4096,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [COV_W-1:0]        coverage,
	input  logic                    last,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [PEAK_VALUE_W-1:0] peak_value,
	output logic [PEAK_COUNT_W-1:0] peak_count
);

	hmf_cmd_t  cmd;
	hmf_stat_t stat;

	// sequencing: clear sweep, accept, update
	hmf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// histogram memory, running best, result register
	hmf_datapath #(
		.BINS        (BINS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.coverage   (coverage),
		.last       (last),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.peak_value (peak_value),
		.peak_count (peak_count)
	);

endmodule

FILE: test/tb_top.sv
// Self-checking bench for histogram_mode_finder_core: a mode predictor is fed every
// accepted coverage transfer, and each peak transfer is checked against it.
// Depends on hmf_pkg and the histogram_mode_finder_core RTL.
`timescale 1ns / 1ps

module tb_top;
	import hmf_pkg::*;

	localparam int BINS         = 4096;
	localparam int COUNT_WIDTH  = 16;
	localparam int RANDOM_ITEMS = 900;
	localparam int MAX_GAP      = 16;
	localparam int MAX_REPORTS  = 10;
	// every transfer may end a run and pay a full clear sweep; the extra
	// items cover directed runs and run overshoot; then margin on top
	localparam int CYCLE_LIMIT  =
		4 * ((RANDOM_ITEMS + 200) * (BINS + 64) + 100 * BINS);
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic [PEAK_VALUE_W-1:0] value;
		logic [PEAK_COUNT_W-1:0] count;
	} peak_t;

	logic                    clk;
	logic                    arst_n    = 1'b0;
	logic                    in_valid  = 1'b0;
	logic                    in_ready;
	logic [COV_W-1:0]        coverage  = '0;
	logic                    last      = 1'b0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [PEAK_VALUE_W-1:0] peak_value;
	logic [PEAK_COUNT_W-1:0] peak_count;

	int send_idle_pct = 38;
	int recv_idle_pct = 60;
	int error_count   = 0;
	int cycle_count   = 0;

	// predictor state: per-bin counts and the running best of the open run
	logic [COUNT_WIDTH-1:0]  hist_bins [BINS];
	logic [PEAK_VALUE_W-1:0] run_best_value;
	logic [COUNT_WIDTH-1:0]  run_best_count;
	peak_t                   expected_peaks [$];

	histogram_mode_finder_core #(
		.BINS        (BINS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.coverage   (coverage),
		.last       (last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.peak_value (peak_value),
		.peak_count (peak_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Mode predictor
	// ---------------------------------------------------------------
	function automatic void clear_tally();
		foreach (hist_bins[i])
			hist_bins[i] = '0;
		run_best_value = '0;
		run_best_count = '0;
	endfunction

	// Bump the bin, keep the running best (smaller bin wins a tie), and on the
	// final transfer of a run queue the peak and start a fresh histogram.
	function automatic void tally_coverage(input logic [COV_W-1:0] cov, input logic lst);
		int                     bin;
		logic [COUNT_WIDTH-1:0] cnt;
		peak_t                  pk;
		bin = (cov > BINS - 1) ? BINS - 1 : int'(cov);
		cnt = hist_bins[bin];
		if (cnt != COUNT_MAX)
			cnt = cnt + 1'b1;
		hist_bins[bin] = cnt;
		if (cnt > run_best_count || (cnt == run_best_count && bin < run_best_value)) begin
			run_best_count = cnt;
			run_best_value = bin[PEAK_VALUE_W-1:0];
		end
		if (lst) begin
			pk.value = run_best_value;
			pk.count = run_best_count[PEAK_COUNT_W-1:0];
			expected_peaks.insert(expected_peaks.size(), pk);
			clear_tally();
		end
	endfunction

	// ---------------------------------------------------------------
	// Stimulus side
	// ---------------------------------------------------------------
	// One coverage transfer. An optional idle gap comes first; valid then stays
	// up with a stable payload until the transfer completes. Always called and
	// returns at a rising edge.
	task automatic send_item(input logic [COV_W-1:0] cov, input logic lst);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		coverage <= cov;
		last     <= lst;
		do
			@(posedge clk);
		while (!in_ready);
		tally_coverage(cov, lst);
	endtask

	// Hold the sender off until every queued peak has been seen.
	task automatic wait_for_peaks();
		if (expected_peaks.size() != 0) begin
			in_valid <= 1'b0;
			while (expected_peaks.size() != 0)
				@(posedge clk);
		end
	endtask

	// Values cluster around a per-run base so repeats and ties are common.
	function automatic logic [COV_W-1:0] random_coverage(input logic [COV_W-1:0] base);
		logic [COV_W-1:0] v;
		case ($urandom_range(7))
			0, 1, 2, 3: v = base + COV_W'($urandom_range(5));
			4, 5:       v = COV_W'($urandom_range(BINS - 1));
			6:          v = $urandom_range(1) ? '1 : '0;
			default:    v = base ^ (COV_W'(1) << $urandom_range(COV_W - 1));
		endcase
		return v;
	endfunction

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	// One-transfer runs at the field extremes and alternating bit patterns.
	task automatic test_single_runs();
		send_item(12'h000, 1'b1);
		send_item(12'hFFF, 1'b1);
		send_item(12'hAAA, 1'b1);
		send_item(12'h555, 1'b1);
	endtask

	// Tie handling: the smaller value must win whichever arrives first.
	task automatic test_ties();
		send_item(12'd9, 1'b0);
		send_item(12'd9, 1'b0);
		send_item(12'd5, 1'b0);
		send_item(12'd5, 1'b1);
		send_item(12'd5, 1'b0);
		send_item(12'd5, 1'b0);
		send_item(12'd9, 1'b0);
		send_item(12'd9, 1'b1);
		send_item(12'hFFF, 1'b0);
		send_item(12'h000, 1'b0);
		send_item(12'hFFF, 1'b1);
		send_item(12'd7, 1'b0);
		send_item(12'd3, 1'b0);
		send_item(12'd7, 1'b0);
		send_item(12'd3, 1'b1);
	endtask

	// Sender stops until the result is out, then starts a new run.
	task automatic test_pause_for_results();
		send_item(12'd1, 1'b0);
		send_item(12'd2, 1'b0);
		send_item(12'd2, 1'b1);
		wait_for_peaks();
		send_item(12'd2, 1'b0);
		send_item(12'd1, 1'b1);
		wait_for_peaks();
	endtask

	// Random runs of random length; now and then the sender drains first.
	task automatic test_random_runs(input int n_items, input int s_pct, input int r_pct);
		int               sent;
		int               len;
		logic [COV_W-1:0] base;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		sent = 0;
		while (sent < n_items) begin
			len  = ($urandom_range(7) == 0) ? 1 : $urandom_range(40, 2);
			base = COV_W'($urandom_range(BINS - 1));
			for (int k = 0; k < len; k++)
				send_item(random_coverage(base), k == len - 1);
			sent += len;
			if ($urandom_range(9) == 0)
				wait_for_peaks();
		end
	endtask

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	initial begin
		clear_tally();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// first transfers simply wait out the post-reset clear sweep
		test_single_runs();
		test_ties();
		test_pause_for_results();
		test_random_runs(RANDOM_ITEMS / 3, 38, 60);
		test_random_runs(RANDOM_ITEMS / 3, 60, 38);
		test_random_runs(RANDOM_ITEMS / 3, 0, 0);
		in_valid <= 1'b0;
		while (expected_peaks.size() != 0)
			@(posedge clk);
		// catch any stray result after the last expected one
		repeat (50) @(posedge clk);
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Receiver backpressure, redrawn every cycle.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Peak checker: every result transfer is matched to the oldest prediction.
	always @(posedge clk) begin : check_peaks
		peak_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_peaks.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("unexpected peak: value=%0d count=%0d", peak_value, peak_count);
			end else begin
				want = expected_peaks.pop_front();
				if (peak_value !== want.value || peak_count !== want.count) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("peak mismatch: value exp=%0d got=%0d, count exp=%0d got=%0d",
							want.value, peak_value, want.count, peak_count);
				end
			end
		end
	end

	// Watchdog.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

endmodule
